/* src/swpr_pkg.sv */
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared widths, codes and types of the sliding window peak rate block.
// ----------------------------------------------------------------------------
package swpr_pkg;

  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CLASS_W    = 4;
  localparam int WIN_W      = 13;
  localparam int MAX_WIN    = (2 ** WIN_W) - 1;
  localparam int MOD_X_W    = TIME_W + 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FROM_TIME      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TO_TIME        = 2'd2;

  localparam logic [CLASS_W-1:0] SERVER_ERROR_CLASS = 4'd5;

  typedef enum logic {
    KIND_SKIP,
    KIND_TRACK
  } item_kind_t;

  // one classified event on its way from the front to the back
  typedef struct packed {
    item_kind_t        kind;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] last_time;
    logic [CNT_W-1:0]  error_count;
    logic              stopped;
  } q_item_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_START,
    BK_CLASS,
    BK_IDX_MOD,
    BK_RD,
    BK_WR,
    BK_OFF_MOD,
    BK_CLR,
    BK_K_MOD,
    BK_RESULT
  } back_state_t;

endpackage

/* src/swpr_if.sv */
// ----------------------------------------------------------------------------
// swpr_if
// Valid/ready channels for events in and peak reports out.
// ----------------------------------------------------------------------------
interface swpr_event_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_time;
  logic [3:0]  status_class;

  modport source (output valid, output event_time, output status_class, input ready);
  modport sink (input valid, input event_time, input status_class, output ready);
endinterface

interface swpr_report_if;
  logic        valid;
  logic        ready;
  logic [31:0] best_start;
  logic [31:0] best_end;
  logic [31:0] best_count;
  logic [31:0] error_count;
  logic        stopped;

  modport source (output valid, output best_start, output best_end, output best_count,
                  output error_count, output stopped, input ready);
  modport sink (input valid, input best_start, input best_end, input best_count,
                input error_count, input stopped, output ready);
endinterface

/* src/sliding_window_peak_rate_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_peak_rate_top
// Busiest window of log events over a ring of per-second counts. Each event
// transaction yields one report transaction. After reset the ring RAM is
// zeroed, and no event is taken until that is done. An event that lands
// inside the current window costs the back end one RAM read-modify-write.
// An event that slides the window also clears the slot of each second that
// drops out, up to the window length, and then reduces the new ring offset.
// Ring index reduction takes at most one subtraction while the value is
// below twice the window and otherwise runs through a bit-serial remainder
// unit; that slow path is taken for a jump of about three windows or more
// past the window start, and after the window length has been changed
// mid-run. A two-entry queue lets the front take events while the back end
// works and a report waits in its output register.
// ----------------------------------------------------------------------------
module sliding_window_peak_rate_top #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  swpr_event_if.sink                       events,
  swpr_report_if.source                    report
);
  import swpr_pkg::*;

  logic             push;
  logic             q_ready;
  q_item_t          push_item;
  logic             q_valid;
  logic             q_pop;
  q_item_t          head_item;
  logic             init_done;
  logic [WIN_W-1:0] window_seconds;

  swpr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .events         (events),
    .init_done      (init_done),
    .q_ready        (q_ready),
    .push           (push),
    .item           (push_item),
    .window_seconds (window_seconds)
  );

  swpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (q_ready),
    .in_item   (push_item),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_item  (head_item)
  );

  swpr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .window_seconds (window_seconds),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (head_item),
    .init_done      (init_done),
    .report         (report)
  );

endmodule

/* src/swpr_ram.sv */
// ----------------------------------------------------------------------------
// swpr_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/swpr_mod.sv */
// ----------------------------------------------------------------------------
// swpr_mod
// Remainder unit: x mod w, at most one subtraction when x < 2w, else bit-serial restoring.
// ----------------------------------------------------------------------------
module swpr_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [swpr_pkg::MOD_X_W-1:0] x,
  input  logic [swpr_pkg::WIN_W-1:0]   w,
  output logic                        done,
  output logic [swpr_pkg::WIN_W-1:0]   r
);
  import swpr_pkg::*;

  localparam int CW = $clog2(MOD_X_W + 1);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [MOD_X_W-1:0] dividend;
  logic [MOD_X_W-1:0] x_less_w;
  logic [WIN_W:0]     shifted;
  logic [WIN_W:0]     trial;
  logic [WIN_W-1:0]   rem_next;

  assign x_less_w = x - MOD_X_W'(w);
  assign shifted  = {r, dividend[MOD_X_W-1]};
  assign trial    = shifted - {1'b0, w};
  assign rem_next = (shifted >= {1'b0, w}) ? trial[WIN_W-1:0] : shifted[WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (x < MOD_X_W'(w)) begin
          r    <= x[WIN_W-1:0];
          done <= 1'b1;
        end else if (x_less_w < MOD_X_W'(w)) begin
          r    <= x_less_w[WIN_W-1:0];
          done <= 1'b1;
        end else begin
          busy     <= 1'b1;
          dividend <= x;
          r        <= '0;
          cnt      <= CW'(MOD_X_W);
        end
      end else if (busy) begin
        r        <= rem_next;
        dividend <= dividend << 1;
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/swpr_front.sv */
// ----------------------------------------------------------------------------
// swpr_front
// Configuration registers, time filter, stop logic and 5xx counter.
// ----------------------------------------------------------------------------
module swpr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  swpr_event_if.sink                     events,
  input  logic                           init_done,
  input  logic                           q_ready,
  output logic                           push,
  output swpr_pkg::q_item_t              item,
  output logic [swpr_pkg::WIN_W-1:0]     window_seconds
);
  import swpr_pkg::*;

  logic [TIME_W-1:0] time_floor;
  logic [TIME_W-1:0] to_time;
  logic              halted;
  logic [CNT_W-1:0]  server_errors;
  logic [TIME_W-1:0] last_time;
  logic              take;
  logic              stop;
  logic              track;
  logic              is_error;

  assign events.ready = init_done && q_ready;
  assign push         = events.valid && events.ready;

  always_comb begin
    take     = !halted && (events.event_time >= time_floor);
    stop     = take && (to_time != '0) && (events.event_time > to_time);
    track    = take && !stop;
    is_error = track && (events.status_class == SERVER_ERROR_CLASS);
    item.kind        = track ? KIND_TRACK : KIND_SKIP;
    item.event_time  = events.event_time;
    item.last_time   = track ? events.event_time : last_time;
    item.error_count = server_errors + CNT_W'(is_error);
    item.stopped     = halted || stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= '0;
      time_floor     <= '0;
      to_time        <= '0;
      halted         <= 1'b0;
      server_errors  <= '0;
      last_time      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SECONDS: window_seconds <= cfg_data[WIN_W-1:0];
          CFG_FROM_TIME:      time_floor     <= cfg_data[TIME_W-1:0];
          CFG_TO_TIME:        to_time        <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        halted        <= item.stopped;
        server_errors <= item.error_count;
        last_time     <= item.last_time;
      end
    end
  end

endmodule

/* src/swpr_queue.sv */
// ----------------------------------------------------------------------------
// swpr_queue
// Short FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module swpr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swpr_pkg::q_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output swpr_pkg::q_item_t out_item
);
  import swpr_pkg::*;

  q_item_t        slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign in_ready  = (count != (QAW + 1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* src/swpr_back.sv */
// ----------------------------------------------------------------------------
// swpr_back
// Window tracker: per-second ring in RAM, slide and clear, best window report.
// ----------------------------------------------------------------------------
module swpr_back #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [swpr_pkg::WIN_W-1:0] window_seconds,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  swpr_pkg::q_item_t          q_item,
  output logic                       init_done,
  swpr_report_if.source              report
);
  import swpr_pkg::*;

  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RD_CAP = (RING_DEPTH > MAX_WIN) ? MAX_WIN : RING_DEPTH;

  back_state_t state;
  back_state_t state_next;

  q_item_t           it;
  logic              started;
  logic [TIME_W-1:0] wl;
  logic [TIME_W-1:0] wh;
  logic [WIN_W-1:0]  ring_offset;
  logic [CNT_W-1:0]  cur_total;
  logic [CNT_W-1:0]  best_total;
  logic [TIME_W-1:0] best_low;
  logic [TIME_W-1:0] best_high;
  logic [WIN_W-1:0]  idx;
  logic [WIN_W-1:0]  ptr;
  logic [WIN_W-1:0]  clr_cnt;
  logic              pend;
  logic [WIN_W-1:0]  pend_addr;
  logic [TIME_W-1:0] k;
  logic [AW-1:0]     init_addr;

  logic [WIN_W-1:0]  w_eff;
  logic              in_win;
  logic              past;
  logic [TIME_W:0]   end_sum;
  logic [TIME_W-1:0] k_calc;
  logic [WIN_W-1:0]  n_clr;
  logic [WIN_W:0]    ro_sum;
  logic [WIN_W-1:0]  ro_new;
  logic [WIN_W-1:0]  last_idx;
  logic              out_free;
  logic [CNT_W-1:0]  rep_count;
  logic [TIME_W-1:0] rep_low;
  logic [TIME_W-1:0] rep_high;

  logic               mod_start;
  logic [MOD_X_W-1:0] mod_x;
  logic               mod_done;
  logic [WIN_W-1:0]   mod_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  logic              out_valid;
  logic [TIME_W-1:0] out_start;
  logic [TIME_W-1:0] out_end;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  out_errors;
  logic              out_stopped;

  swpr_ram #(.WIDTH(CNT_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swpr_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mod_x),
    .w     (w_eff),
    .done  (mod_done),
    .r     (mod_r)
  );

  assign init_done = (state != BK_INIT);
  assign out_free  = !out_valid || report.ready;

  assign report.valid       = out_valid;
  assign report.best_start  = out_start;
  assign report.best_end    = out_end;
  assign report.best_count  = out_count;
  assign report.error_count = out_errors;
  assign report.stopped     = out_stopped;

  always_comb begin
    w_eff = (32'(window_seconds) > 32'(RD_CAP)) ? WIN_W'(RD_CAP) : window_seconds;
    in_win  = (it.event_time >= wl) && (it.event_time <= wh);
    past    = ({1'b0, wl} + (TIME_W + 1)'(w_eff)) <= {1'b0, it.event_time};
    end_sum = {1'b0, it.event_time} + (TIME_W + 1)'(w_eff) - (TIME_W + 1)'(1);
    k_calc  = it.event_time - wl - TIME_W'(w_eff) + TIME_W'(1);
    n_clr   = (k_calc < TIME_W'(w_eff)) ? k_calc[WIN_W-1:0] : w_eff;
    ro_sum  = {1'b0, ring_offset} + {1'b0, mod_r};
    ro_new  = (ro_sum >= {1'b0, w_eff}) ? WIN_W'(ro_sum - {1'b0, w_eff})
                                        : ro_sum[WIN_W-1:0];
    last_idx = (ro_new == '0) ? w_eff - 1'b1 : ro_new - 1'b1;
    // report as at end of log: one last compare, end clamped
    if (cur_total > best_total) begin
      rep_count = cur_total;
      rep_low   = wl;
      rep_high  = wh;
    end else begin
      rep_count = best_total;
      rep_low   = best_low;
      rep_high  = best_high;
    end
    if (rep_high > it.last_time) begin
      rep_high = it.last_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mod_start  = 1'b0;
    mod_x      = '0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(idx);
    ram_wdata  = '0;
    ram_raddr  = AW'(idx);
    case (state)
      BK_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_addr;
        if (init_addr == AW'(RING_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = ((q_item.kind == KIND_TRACK) && (w_eff != '0)) ? BK_START : BK_RESULT;
        end
      end
      BK_START: state_next = BK_CLASS;
      BK_CLASS: begin
        mod_start = 1'b1;
        if (in_win) begin
          mod_x      = MOD_X_W'(ring_offset) + MOD_X_W'(it.event_time - wl);
          state_next = BK_IDX_MOD;
        end else if (past) begin
          mod_x      = MOD_X_W'(ring_offset);
          state_next = BK_OFF_MOD;
        end else begin
          mod_x      = MOD_X_W'(ring_offset) + MOD_X_W'(w_eff) - MOD_X_W'(1);
          state_next = BK_IDX_MOD;
        end
      end
      BK_IDX_MOD: begin
        if (mod_done) begin
          state_next = BK_RD;
        end
      end
      BK_RD: state_next = BK_WR;
      BK_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata + CNT_W'(1);
        state_next = BK_RESULT;
      end
      BK_OFF_MOD: begin
        if (mod_done) begin
          state_next = BK_CLR;
        end
      end
      BK_CLR: begin
        // read one slot a cycle, zero it the cycle after
        ram_raddr = AW'(ptr);
        ram_we    = pend;
        ram_waddr = AW'(pend_addr);
        if ((clr_cnt == '0) && !pend) begin
          mod_start  = 1'b1;
          mod_x      = MOD_X_W'(k);
          state_next = BK_K_MOD;
        end
      end
      BK_K_MOD: begin
        if (mod_done) begin
          state_next = BK_RD;
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      wl          <= '0;
      wh          <= '0;
      ring_offset <= '0;
      cur_total   <= '0;
      best_total  <= '0;
      best_low    <= '0;
      best_high   <= '0;
      pend        <= 1'b0;
      clr_cnt     <= '0;
      init_addr   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == BK_INIT) begin
        init_addr <= init_addr + AW'(1);
      end
      if (q_pop) begin
        it <= q_item;
      end
      if ((state == BK_START) && !started) begin
        started <= 1'b1;
        wl      <= it.event_time;
        wh      <= end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
      end
      if ((state == BK_CLASS) && !in_win) begin
        if (cur_total > best_total) begin
          best_total <= cur_total;
          best_low   <= wl;
          best_high  <= wh;
        end
        wh <= it.event_time;
        if (past) begin
          k       <= k_calc;
          clr_cnt <= n_clr;
        end
      end
      if ((state == BK_IDX_MOD) && mod_done) begin
        idx <= mod_r;
      end
      if ((state == BK_OFF_MOD) && mod_done) begin
        ptr         <= mod_r;
        ring_offset <= mod_r;
      end
      if (state == BK_CLR) begin
        if (clr_cnt != '0) begin
          pend      <= 1'b1;
          pend_addr <= ptr;
          clr_cnt   <= clr_cnt - 1'b1;
          ptr       <= (({1'b0, ptr} + (WIN_W + 1)'(1)) == {1'b0, w_eff}) ? '0 : ptr + 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend) begin
          cur_total <= cur_total - ram_rdata;
        end
      end
      if ((state == BK_K_MOD) && mod_done) begin
        ring_offset <= ro_new;
        wl          <= it.event_time - TIME_W'(w_eff) + TIME_W'(1);
        idx         <= last_idx;
      end
      if (state == BK_WR) begin
        cur_total <= cur_total + CNT_W'(1);
      end
      if ((state == BK_RESULT) && out_free) begin
        out_valid   <= 1'b1;
        out_start   <= rep_low;
        out_end     <= rep_high;
        out_count   <= rep_count;
        out_errors  <= it.error_count;
        out_stopped <= it.stopped;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> (w_eff != '0))
    else $error("remainder unit started with zero window");

  a_offset_in_ring: assert property (@(posedge clk) disable iff (rst)
    ((state == BK_K_MOD) && mod_done) |=> (ring_offset < w_eff))
    else $error("ring offset not reduced below window after slide");

  a_clear_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLR) |-> (clr_cnt <= w_eff))
    else $error("clear count exceeds window");

  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("window tracking lost its start");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window peak rate block. Events go in
// over a valid/ready channel with random gaps and every report is compared
// with a cycle-free model of the ring of per-second counts. The window
// length, start time and stop time change between phases. Directed events
// open and close the run, with random timestamp sequences in between.
// ----------------------------------------------------------------------------
module tb_top;
  import swpr_pkg::*;

  localparam int          RING_SLOTS    = 4096;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int          SETTLE_CYCLES = 100;

  typedef struct {
    logic [TIME_W-1:0] best_start;
    logic [TIME_W-1:0] best_end;
    logic [CNT_W-1:0]  best_count;
    logic [CNT_W-1:0]  error_count;
    logic              stopped;
  } report_t;

  // Model of the block: ring of per-second counts plus best window so far
  class peak_window_tracker;
    bit [CNT_W-1:0]  slot_count [RING_SLOTS];
    bit [TIME_W-1:0] win_lo, win_hi, best_lo, best_hi, last_seen;
    bit [CNT_W-1:0]  cur_total, best_total, err_total;
    bit [31:0]       ring_base;
    bit              opened, halted;
    bit [WIN_W-1:0]  win_len;
    bit [TIME_W-1:0] from_t, to_t;
    report_t         pending_reports[$];
    int unsigned     mismatches;

    function void set_register(logic [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WINDOW_SECONDS: win_len = value[WIN_W-1:0];
        CFG_FROM_TIME:      from_t = value;
        CFG_TO_TIME:        to_t = value;
        default: ;
      endcase
    endfunction

    function void count_event(bit [TIME_W-1:0] t);
      longint unsigned w, k, n, i, idx, t64, lo64, span;
      w = (win_len > RING_SLOTS) ? RING_SLOTS : win_len;
      if (w == 0) return;
      t64 = t;
      if (!opened) begin
        opened = 1'b1;
        win_lo = t;
        span = t64 + w - 1;
        win_hi = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      end
      if (t >= win_lo && t <= win_hi) begin
        lo64 = win_lo;
        idx = (ring_base + (t64 - lo64)) % w;
        slot_count[idx] += 1;
      end else begin
        if (cur_total > best_total) begin
          best_total = cur_total;
          best_lo = win_lo;
          best_hi = win_hi;
        end
        win_hi = t;
        lo64 = win_lo;
        if (lo64 + w <= t64) begin
          // slide: drop at most a full window of seconds
          k = t64 - lo64 - w + 1;
          n = (k < w) ? k : w;
          for (i = 0; i < n; i++) begin
            idx = (ring_base + i) % w;
            cur_total -= slot_count[idx];
            slot_count[idx] = '0;
          end
          ring_base = 32'(((ring_base % w) + (k % w)) % w);
          win_lo = t - 32'(w) + 32'd1;
        end
        idx = (ring_base + w - 1) % w;
        slot_count[idx] += 1;
      end
      cur_total += 1;
    endfunction

    function void note_event(bit [TIME_W-1:0] t, bit [CLASS_W-1:0] cls);
      report_t want;
      if (!halted && t >= from_t) begin
        if (to_t != 0 && t > to_t) begin
          halted = 1'b1;
        end else begin
          count_event(t);
          if (cls == SERVER_ERROR_CLASS) err_total += 1;
          last_seen = t;
        end
      end
      want.best_count = best_total;
      want.best_start = best_lo;
      want.best_end = best_hi;
      if (cur_total > best_total) begin
        want.best_count = cur_total;
        want.best_start = win_lo;
        want.best_end = win_hi;
      end
      if (want.best_end > last_seen) want.best_end = last_seen;
      want.error_count = err_total;
      want.stopped = halted;
      pending_reports.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("report with no event outstanding: best_count %0d", got.best_count);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("best_start", want.best_start, got.best_start);
      compare_field("best_end", want.best_end, got.best_end);
      compare_field("best_count", want.best_count, got.best_count);
      compare_field("error_count", want.error_count, got.error_count);
      compare_field("stopped", 32'(want.stopped), 32'(got.stopped));
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  bit calm;
  bit [TIME_W-1:0] now;
  int unsigned cycle_count;

  swpr_event_if  ev_ch ();
  swpr_report_if rp_ch ();

  peak_window_tracker tracker = new();

  sliding_window_peak_rate_top #(
    .RING_DEPTH(RING_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_ch),
    .report    (rp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_length();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(bit [TIME_W-1:0] t, bit [CLASS_W-1:0] cls);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.event_time <= t;
    ev_ch.status_class <= cls;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    tracker.note_event(t, cls);
  endtask

  // all three registers back to back, with the block idle
  task automatic apply_settings(bit [WIN_W-1:0] w, bit [TIME_W-1:0] from_v,
                                bit [TIME_W-1:0] to_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW_SECONDS;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FROM_TIME;
    cfg_data <= from_v;
    @(posedge clk);
    cfg_index <= CFG_TO_TIME;
    cfg_data <= to_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(CFG_WINDOW_SECONDS, CFG_DATA_W'(w));
    tracker.set_register(CFG_FROM_TIME, from_v);
    tracker.set_register(CFG_TO_TIME, to_v);
  endtask

  task automatic settle();
    ev_ch.valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic hold_off();
    if (tracker.pending_reports.size() != 0) begin
      ev_ch.valid <= 1'b0;
      do @(posedge clk); while (tracker.pending_reports.size() != 0);
    end
  endtask

  function automatic bit [CLASS_W-1:0] pick_class();
    if ($urandom_range(0, 3) == 0) return SERVER_ERROR_CLASS;
    return CLASS_W'($urandom_range(0, 9));
  endfunction

  task automatic random_phase();
    int r, count, scale;
    bit [WIN_W-1:0]  w;
    bit [TIME_W-1:0] from_v, to_v, t;
    r = $urandom_range(0, 99);
    if (r < 8) w = 0;
    else if (r < 13) w = WIN_W'(RING_SLOTS);
    else if (r < 18) w = WIN_W'($urandom_range(1000, RING_SLOTS - 1));
    else if (r < 30) w = 1;
    else w = WIN_W'($urandom_range(2, 40));
    from_v = ($urandom_range(0, 1) == 0) ? '0 : now + $urandom_range(0, 30);
    r = $urandom_range(0, 2);
    to_v = (r == 0) ? '0 : (r == 1) ? 32'hFFFF_FFFF : now + 32'h1000_0000;
    apply_settings(w, from_v, to_v);
    calm = ($urandom_range(0, 99) < 20);
    scale = (w < 4) ? 4 : int'(w);
    count = $urandom_range(24, 34);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5 && now > TIME_W'(scale + 3)) begin
        // out of order timestamp, may land before the window start
        t = now - $urandom_range(1, scale + 2);
      end else begin
        if (r < 65) now += $urandom_range(0, 2);
        else if (r < 82) now += $urandom_range(1, scale);
        else if (r < 95) now += scale + $urandom_range(0, scale + 4);
        else now += $urandom_range(2 * scale, 3 * scale + 1000);
        t = now;
      end
      send_event(t, pick_class());
      if (n == 10 || $urandom_range(0, 99) < 3) hold_off();
    end
    settle();
  endtask

  initial begin : report_sink
    int hold;
    report_t got;
    hold = 0;
    rp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rp_ch.valid && rp_ch.ready) begin
        got.best_start = rp_ch.best_start;
        got.best_end = rp_ch.best_end;
        got.best_count = rp_ch.best_count;
        got.error_count = rp_ch.error_count;
        got.stopped = rp_ch.stopped;
        tracker.check_report(got);
      end
      if (hold > 0) begin
        hold--;
        rp_ch.ready <= 1'b0;
      end else begin
        hold = idle_length();
        if (hold > 0) begin
          hold--;
          rp_ch.ready <= 1'b0;
        end else begin
          rp_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sliding_window_peak_rate_top verification failed");
    $finish;
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WINDOW_SECONDS;
    cfg_data <= '0;
    ev_ch.valid <= 1'b0;
    ev_ch.event_time <= '0;
    ev_ch.status_class <= '0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short window: zero timestamp, in-window counts, one-second slide,
    // jump past a whole window, then an event before the window start
    apply_settings(3, 32'd0, 32'hFFFF_FFFF);
    send_event(32'd0, SERVER_ERROR_CLASS);
    send_event(32'd0, 4'd9);
    send_event(32'd1, 4'd0);
    send_event(32'd2, 4'd7);
    send_event(32'd3, SERVER_ERROR_CLASS);
    send_event(32'd9, 4'd2);
    send_event(32'd5, 4'd8);
    send_event(32'd10, 4'd1);
    settle();

    // full ring, reached mid-run
    apply_settings(WIN_W'(RING_SLOTS), 32'd0, 32'd0);
    send_event(32'd11, 4'd3);
    send_event(32'd11, SERVER_ERROR_CLASS);
    send_event(32'd4200, 4'd4);
    send_event(32'd4201, 4'd6);
    settle();

    // tracking off: window frozen, errors still counted
    apply_settings(0, 32'd0, 32'd0);
    send_event(32'd4300, SERVER_ERROR_CLASS);
    send_event(32'd4301, 4'd2);
    settle();

    // one-second window behind a start time
    apply_settings(1, 32'd5000, 32'd0);
    send_event(32'd4999, SERVER_ERROR_CLASS);
    send_event(32'd5000, 4'd1);
    send_event(32'd5000, 4'd9);
    send_event(32'd5001, 4'd5);
    send_event(32'd5003, 4'd0);
    settle();

    now = 32'd6000;
    repeat (13) random_phase();
    calm = 1'b0;

    // top of the time range, then the stop time
    apply_settings(2, 32'hFFFF_FFFF, 32'd0);
    send_event(32'h7FFF_FFFF, SERVER_ERROR_CLASS);
    send_event(32'hFFFF_FFFE, 4'd3);
    send_event(32'hFFFF_FFFF, SERVER_ERROR_CLASS);
    settle();
    apply_settings(1, 32'd0, 32'hFFFF_FFFE);
    send_event(32'hFFFF_FFFE, 4'd2);
    send_event(32'hFFFF_FFFF, 4'd8);
    send_event(32'hFFFF_FFFF, SERVER_ERROR_CLASS);
    send_event(32'd3, 4'd1);
    settle();

    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("sliding_window_peak_rate_top verification clean");
    end else begin
      $display("sliding_window_peak_rate_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/swpr_pkg.sv
src/swpr_if.sv
src/swpr_ram.sv
src/swpr_mod.sv
src/swpr_front.sv
src/swpr_queue.sv
src/swpr_back.sv
src/sliding_window_peak_rate_top.sv
verif/tb_top.sv
